// ===== src/swmf_pkg.sv =====
package swmf_pkg;

  localparam int WINDOW_LEN = 13;
  localparam int CODE_W     = 8;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int TREE_N     = 1 << $clog2(WINDOW_LEN);
  localparam int KEY_W      = CNT_W + CODE_W;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [KEY_W-1:0]  key_t;

endpackage

// ===== src/sliding_window_mode_filter.sv =====
// Sliding-window mode filter.
// Pipeline: a count stage, then a combinational max tree on the count registers
//   that feeds the output register.
// Throughput: one beat per cycle; the two stages each stall only on a full next stage.
// Reset (rst_n low, synchronous): fill code 0, window all 0, write slot 0,
//   both stages empty.
module sliding_window_mode_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  swmf_pkg::code_t      cfg_fill_code,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  swmf_pkg::code_t      in_class_code,
  input  logic                 in_record_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output swmf_pkg::code_t      out_mode_code
);
  import swmf_pkg::*;

  // configuration
  code_t fill_r;

  // window state
  code_t win_r   [WINDOW_LEN];
  code_t win_nxt [WINDOW_LEN];
  slot_t slot_r, slot_nxt;

  // count stage
  logic  s1_vld_r;
  code_t s1_code_r [WINDOW_LEN];
  cnt_t  s1_cnt_r  [WINDOW_LEN];
  cnt_t  cnt_nxt   [WINDOW_LEN];

  // output stage
  logic  out_vld_r;
  code_t out_code_r, out_code_nxt;
  key_t  tree [2*TREE_N];

  logic in_acc, s1_ready, s2_ready, s2_load;

  assign cfg_ready = 1'b1;

  // Each stage takes a new beat when empty or when its content moves on.
  assign s2_ready = !out_vld_r || out_ready;
  assign s2_load  = s1_vld_r && s2_ready;
  assign s1_ready = !s1_vld_r || s2_ready;
  assign in_ready = s1_ready;
  assign in_acc   = in_valid && in_ready;

  assign out_valid     = out_vld_r;
  assign out_mode_code = out_code_r;

  // Window after this beat: optional refill from the fill code, then insert.
  // On record start the insert always lands in slot 0.
  always_comb begin
    slot_t ins;
    ins = in_record_start ? '0 : slot_r;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      win_nxt[i] = in_record_start ? fill_r : win_r[i];
      if (slot_t'(i) == ins) begin
        win_nxt[i] = in_class_code;
      end
    end
    if (ins == slot_t'(WINDOW_LEN - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = ins + slot_t'(1);
    end
  end

  // Occurrence count of every entry over the whole new window.
  always_comb begin
    logic [WINDOW_LEN-1:0] eq;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      eq = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        eq[j] = (win_nxt[j] == win_nxt[i]);
      end
      cnt_nxt[i] = CNT_W'($countones(eq));
    end
  end

  // Max tree on {count, ~code}: highest count wins, smallest code on ties.
  // Pad leaves carry count 0 and never beat a real entry (count >= 1).
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      if (i < WINDOW_LEN) begin
        tree[TREE_N + i] = {s1_cnt_r[i], ~s1_code_r[i]};
      end else begin
        tree[TREE_N + i] = '0;
      end
    end
    tree[0] = '0;
    for (int i = TREE_N - 1; i >= 1; i--) begin
      tree[i] = (tree[2*i] >= tree[2*i+1]) ? tree[2*i] : tree[2*i+1];
    end
    out_code_nxt = ~tree[1][CODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      slot_r    <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        fill_r <= cfg_fill_code;
      end
      if (in_acc) begin
        slot_r <= slot_nxt;
        for (int i = 0; i < WINDOW_LEN; i++) begin
          win_r[i] <= win_nxt[i];
        end
      end
      if (s1_ready) begin
        s1_vld_r <= in_acc;
      end
      if (s2_ready) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        s1_code_r[i] <= win_nxt[i];
        s1_cnt_r[i]  <= cnt_nxt[i];
      end
    end
    if (s2_load) begin
      out_code_r <= out_code_nxt;
    end
  end

  // write slot stays inside the window
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= slot_t'(WINDOW_LEN - 1))
    else $error("write slot out of range");

  // a record start restarts the slot: next slot is the one after slot 0
  a_start_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_record_start) |=> (slot_r == slot_t'(1 % WINDOW_LEN)))
    else $error("record start did not restart write slot");

  // an accepted beat always occupies the count stage next cycle
  a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted beat lost before count stage");

  // a result appears only from a filled count stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_vld_r))
    else $error("result without source beat");

endmodule
